// ----- rtl/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, sizes and the control store of the heap sequencer.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int DEPTH     = 64;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int OUT_CNT_W = 7;
  localparam int STEP_W    = 4;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [STEP_W-1:0] {
    S_IDLE       = 4'd0,
    S_DISPATCH   = 4'd1,
    S_PUSH_CHK   = 4'd2,
    S_UP_RD      = 4'd3,
    S_UP_EV      = 4'd4,
    S_UP_END     = 4'd5,
    S_POP_CHK    = 4'd6,
    S_POP_LD     = 4'd7,
    S_DN_RD      = 4'd8,
    S_DN_EV      = 4'd9,
    S_DN_END     = 4'd10,
    S_RESP_OK    = 4'd11,
    S_RESP_EMPTY = 4'd12,
    S_RESP_FULL  = 4'd13
  } step_t;

  typedef enum logic [3:0] {
    C_ALWAYS   = 4'd0,
    C_IN_XFER  = 4'd1,
    C_IS_POP   = 4'd2,
    C_FULL     = 4'd3,
    C_EMPTY    = 4'd4,
    C_POS_ZERO = 4'd5,
    C_UP_MOVE  = 4'd6,
    C_NO_LEFT  = 4'd7,
    C_DN_MOVE  = 4'd8,
    C_OUT_FREE = 4'd9
  } cond_t;

  typedef enum logic [1:0] {
    RD_UP   = 2'd0,
    RD_POP  = 2'd1,
    RD_DOWN = 2'd2
  } rd_t;

  typedef enum logic [2:0] {
    A_NONE       = 3'd0,
    A_PUSH_SETUP = 3'd1,
    A_UP_STEP    = 3'd2,
    A_UP_END     = 3'd3,
    A_POP_SETUP  = 3'd4,
    A_POP_LOAD   = 3'd5,
    A_DN_STEP    = 3'd6,
    A_DN_END     = 3'd7
  } act_t;

  // One control word: accept enable, branch, read port use, datapath action, response.
  typedef struct packed {
    logic    accept;
    cond_t   cond;
    step_t   target;
    logic    hold;
    rd_t     rd;
    act_t    act;
    logic    resp;
    status_t resp_st;
  } ctl_t;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr_a;
    logic [ADDR_W-1:0]        raddr_b;
  } mem_req_t;

  function automatic ctl_t ucode(input step_t s);
    ctl_t c;
    c = '{accept: 1'b0, cond: C_ALWAYS, target: S_IDLE, hold: 1'b0, rd: RD_UP,
          act: A_NONE, resp: 1'b0, resp_st: ST_OK};
    case (s)
      S_IDLE: begin
        c.accept = 1'b1;
        c.cond   = C_IN_XFER;
        c.target = S_DISPATCH;
        c.hold   = 1'b1;
      end
      S_DISPATCH: begin
        c.cond   = C_IS_POP;
        c.target = S_POP_CHK;
      end
      S_PUSH_CHK: begin
        c.cond   = C_FULL;
        c.target = S_RESP_FULL;
        c.act    = A_PUSH_SETUP;
      end
      S_UP_RD: begin
        c.cond   = C_POS_ZERO;
        c.target = S_UP_END;
        c.rd     = RD_UP;
      end
      S_UP_EV: begin
        c.cond   = C_UP_MOVE;
        c.target = S_UP_RD;
        c.act    = A_UP_STEP;
      end
      S_UP_END: begin
        c.cond   = C_ALWAYS;
        c.target = S_RESP_OK;
        c.act    = A_UP_END;
      end
      S_POP_CHK: begin
        c.cond   = C_EMPTY;
        c.target = S_RESP_EMPTY;
        c.rd     = RD_POP;
        c.act    = A_POP_SETUP;
      end
      S_POP_LD: begin
        c.cond   = C_ALWAYS;
        c.target = S_DN_RD;
        c.act    = A_POP_LOAD;
      end
      S_DN_RD: begin
        c.cond   = C_NO_LEFT;
        c.target = S_DN_END;
        c.rd     = RD_DOWN;
      end
      S_DN_EV: begin
        c.cond   = C_DN_MOVE;
        c.target = S_DN_RD;
        c.act    = A_DN_STEP;
      end
      S_DN_END: begin
        c.cond   = C_ALWAYS;
        c.target = S_RESP_OK;
        c.act    = A_DN_END;
      end
      S_RESP_OK: begin
        c.cond    = C_OUT_FREE;
        c.hold    = 1'b1;
        c.resp    = 1'b1;
        c.resp_st = ST_OK;
      end
      S_RESP_EMPTY: begin
        c.cond    = C_OUT_FREE;
        c.hold    = 1'b1;
        c.resp    = 1'b1;
        c.resp_st = ST_EMPTY;
      end
      S_RESP_FULL: begin
        c.cond    = C_OUT_FREE;
        c.hold    = 1'b1;
        c.resp    = 1'b1;
        c.resp_st = ST_FULL;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/mhpq_if.sv -----
// ----------------------------------------------------------------------------
// mhpq channels
// Request and response channels of the heap queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhpq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [mhpq_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface mhpq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mhpq_pkg::DATA_W-1:0]    popped_value;
  logic [1:0]                           status;
  logic [mhpq_pkg::OUT_CNT_W-1:0]       count;

  modport source (output valid, output popped_value, output status, output count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input count,
                  output ready);
endinterface

// ----- rtl/mhpq_store.sv -----
// ----------------------------------------------------------------------------
// mhpq_store
// Heap entry memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mhpq_store (
  input  logic                                clk,
  input  mhpq_pkg::mem_req_t                  req,
  output logic signed [mhpq_pkg::DATA_W-1:0]  rd_a,
  output logic signed [mhpq_pkg::DATA_W-1:0]  rd_b
);

  logic signed [mhpq_pkg::DATA_W-1:0] mem [mhpq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

// ----- rtl/max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit priorities run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each request is a push (opcode 0) or a pop of the largest entry (opcode 1)
// and gives exactly one response with the popped value, a status and the
// entry count after the operation. Requests are handled one at a time. A push
// climbs L levels from the new leaf (L up to 6); a pop moves the last entry to
// the root and descends L levels (L up to 5). Each level costs a memory read
// step and a compare/write step on the single write port of the entry memory.
// A push on a full heap or a pop on an empty one goes from its check step
// straight to the response. The response sits in an output register; the
// next request can be taken in the cycle after the response is loaded there.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
  input  logic       clk,
  input  logic       rst,
  mhpq_in_if.sink    req,
  mhpq_out_if.source rsp
);

  localparam int ADDR_W = mhpq_pkg::ADDR_W;
  localparam int CNT_W  = mhpq_pkg::CNT_W;
  localparam int DATA_W = mhpq_pkg::DATA_W;

  mhpq_pkg::step_t    step, step_next;
  mhpq_pkg::ctl_t     ctl;
  mhpq_pkg::mem_req_t mreq;

  logic [CNT_W-1:0]         count;
  logic                     op;
  logic signed [DATA_W-1:0] cur, popped, rd_a, rd_b, best;
  logic [ADDR_W-1:0]        pos, parent, best_idx;
  logic [CNT_W-1:0]         lft, rgt, cnt_m1;
  logic                     in_xfer, out_free, up_gt, dn_gt, best_r, cond_hit;

  logic                         out_valid;
  logic signed [DATA_W-1:0]     out_popped;
  mhpq_pkg::status_t            out_status;
  logic [mhpq_pkg::OUT_CNT_W-1:0] out_count;

  mhpq_store u_store (
    .clk  (clk),
    .req  (mreq),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // Control store lookup
  always_comb begin
    ctl = mhpq_pkg::ucode(step);
  end

  assign req.ready        = ctl.accept;
  assign rsp.valid        = out_valid;
  assign rsp.popped_value = out_popped;
  assign rsp.status       = out_status;
  assign rsp.count        = out_count;

  assign in_xfer  = req.valid && ctl.accept;
  assign out_free = !out_valid || rsp.ready;

  assign parent = (pos - ADDR_W'(1)) >> 1;
  assign lft    = CNT_W'({pos, 1'b1});
  assign rgt    = lft + CNT_W'(1);
  assign cnt_m1 = count - CNT_W'(1);

  // Larger child; left wins a tie
  assign best_r   = (rgt < count) && (rd_b > rd_a);
  assign best     = best_r ? rd_b : rd_a;
  assign best_idx = best_r ? rgt[ADDR_W-1:0] : lft[ADDR_W-1:0];
  assign up_gt    = cur > rd_a;
  assign dn_gt    = best > cur;

  always_comb begin
    case (ctl.cond)
      mhpq_pkg::C_ALWAYS:   cond_hit = 1'b1;
      mhpq_pkg::C_IN_XFER:  cond_hit = in_xfer;
      mhpq_pkg::C_IS_POP:   cond_hit = (op == mhpq_pkg::OP_POP);
      mhpq_pkg::C_FULL:     cond_hit = (count == CNT_W'(mhpq_pkg::DEPTH));
      mhpq_pkg::C_EMPTY:    cond_hit = (count == '0);
      mhpq_pkg::C_POS_ZERO: cond_hit = (pos == '0);
      mhpq_pkg::C_UP_MOVE:  cond_hit = up_gt;
      mhpq_pkg::C_NO_LEFT:  cond_hit = (lft >= count);
      mhpq_pkg::C_DN_MOVE:  cond_hit = dn_gt;
      mhpq_pkg::C_OUT_FREE: cond_hit = out_free;
      default:              cond_hit = 1'b1;
    endcase
  end

  // Next step: jump on condition, else hold or advance
  always_comb begin
    if (cond_hit) begin
      step_next = ctl.target;
    end else if (ctl.hold) begin
      step_next = step;
    end else begin
      step_next = mhpq_pkg::step_t'(step + mhpq_pkg::STEP_W'(1));
    end
  end

  // Memory port drive
  always_comb begin
    mreq.we    = 1'b0;
    mreq.waddr = pos;
    mreq.wdata = cur;
    case (ctl.act)
      mhpq_pkg::A_UP_STEP: begin
        mreq.we    = up_gt;
        mreq.wdata = rd_a;
      end
      mhpq_pkg::A_DN_STEP: begin
        mreq.we    = dn_gt;
        mreq.wdata = best;
      end
      mhpq_pkg::A_UP_END,
      mhpq_pkg::A_DN_END: begin
        mreq.we = 1'b1;
      end
      default: begin
        mreq.we = 1'b0;
      end
    endcase
    case (ctl.rd)
      mhpq_pkg::RD_POP: begin
        mreq.raddr_a = '0;
        mreq.raddr_b = cnt_m1[ADDR_W-1:0];
      end
      mhpq_pkg::RD_DOWN: begin
        mreq.raddr_a = lft[ADDR_W-1:0];
        mreq.raddr_b = rgt[ADDR_W-1:0];
      end
      default: begin
        mreq.raddr_a = parent;
        mreq.raddr_b = parent;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= mhpq_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (ctl.resp && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (ctl.act)
        mhpq_pkg::A_UP_END: begin
          count <= count + CNT_W'(1);
        end
        mhpq_pkg::A_POP_SETUP: begin
          if (count != '0) begin
            count <= cnt_m1;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op     <= req.opcode;
      cur    <= req.value;
      popped <= '0;
    end
    case (ctl.act)
      mhpq_pkg::A_PUSH_SETUP: begin
        pos <= count[ADDR_W-1:0];
      end
      mhpq_pkg::A_UP_STEP: begin
        if (up_gt) begin
          pos <= parent;
        end
      end
      mhpq_pkg::A_POP_LOAD: begin
        popped <= rd_a;
        cur    <= rd_b;
        pos    <= '0;
      end
      mhpq_pkg::A_DN_STEP: begin
        if (dn_gt) begin
          pos <= best_idx;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
    if (ctl.resp && out_free) begin
      out_popped <= popped;
      out_status <= ctl.resp_st;
      out_count  <= mhpq_pkg::OUT_CNT_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(mhpq_pkg::DEPTH))
    else $error("entry count above depth");

  a_full_resp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == mhpq_pkg::ST_FULL) |->
      (rsp.count == mhpq_pkg::OUT_CNT_W'(mhpq_pkg::DEPTH) && rsp.popped_value == '0))
    else $error("full response with wrong count or value");

  a_empty_resp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == mhpq_pkg::ST_EMPTY) |->
      (rsp.count == '0 && rsp.popped_value == '0))
    else $error("empty response with wrong count or value");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      ($past(step) == mhpq_pkg::S_UP_END || $past(step) == mhpq_pkg::S_POP_CHK))
    else $error("entry count changed outside push commit or pop setup");

endmodule

// ----- dv/tb_max_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking bench for the max-heap queue. A scoreboard keeps its own heap
// and predicts the popped value, status and entry count of every request.
// Directed pushes and pops on the extremes come first, then random fill,
// drain and mixed runs. Sender bursts and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;

  typedef struct {
    mhpq_pkg::op_t                      opcode;
    logic signed [mhpq_pkg::DATA_W-1:0] value;
    bit                                 wait_drain;
  } heap_req_t;

  typedef struct {
    logic signed [mhpq_pkg::DATA_W-1:0] popped_value;
    mhpq_pkg::status_t                  status;
    logic [mhpq_pkg::OUT_CNT_W-1:0]     count;
  } heap_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mhpq_in_if  req_ch ();
  mhpq_out_if rsp_ch ();

  max_heap_priority_queue i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  heap_req_t    pending_ops[$];
  heap_result_t expected_rsp[$];
  int           mismatch_cnt = 0;

  // Scoreboard copy of the heap.
  logic signed [mhpq_pkg::DATA_W-1:0] heap_mem [mhpq_pkg::DEPTH];
  int                                 heap_size = 0;
  // Entry count as planned by the stimulus generator.
  int                                 plan_size = 0;

  function automatic heap_result_t apply_heap_op(mhpq_pkg::op_t op,
                                                 logic signed [mhpq_pkg::DATA_W-1:0] v);
    heap_result_t                       r;
    int                                 pos;
    int                                 up;
    int                                 lft;
    int                                 best;
    logic signed [mhpq_pkg::DATA_W-1:0] tmp;
    r.popped_value = '0;
    r.status       = mhpq_pkg::ST_OK;
    if (op == mhpq_pkg::OP_PUSH) begin
      if (heap_size >= mhpq_pkg::DEPTH) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        pos = heap_size;
        heap_mem[pos] = v;
        heap_size++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_mem[pos] <= heap_mem[up]) break;
          tmp           = heap_mem[pos];
          heap_mem[pos] = heap_mem[up];
          heap_mem[up]  = tmp;
          pos           = up;
        end
      end
    end else if (heap_size == 0) begin
      r.status = mhpq_pkg::ST_EMPTY;
    end else begin
      r.popped_value = heap_mem[0];
      heap_size--;
      heap_mem[0] = heap_mem[heap_size];
      pos = 0;
      forever begin
        lft = 2 * pos + 1;
        if (lft >= heap_size) break;
        best = lft;
        // take the left child on a tie
        if (lft + 1 < heap_size && heap_mem[lft + 1] > heap_mem[lft]) best = lft + 1;
        if (heap_mem[best] <= heap_mem[pos]) break;
        tmp            = heap_mem[pos];
        heap_mem[pos]  = heap_mem[best];
        heap_mem[best] = tmp;
        pos            = best;
      end
    end
    r.count = mhpq_pkg::OUT_CNT_W'(heap_size);
    return r;
  endfunction

  function automatic logic signed [mhpq_pkg::DATA_W-1:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      // narrow range to force plenty of equal priorities
      1, 2, 3: return $signed($urandom_range(0, 15)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(mhpq_pkg::op_t op, logic signed [mhpq_pkg::DATA_W-1:0] v);
    heap_req_t item;
    item.opcode     = op;
    item.value      = v;
    item.wait_drain = 1'b0;
    pending_ops.push_back(item);
    if (op == mhpq_pkg::OP_PUSH && plan_size < mhpq_pkg::DEPTH) plan_size++;
    if (op == mhpq_pkg::OP_POP && plan_size > 0) plan_size--;
  endtask

  task automatic queue_drain_pause();
    heap_req_t item;
    item.opcode     = mhpq_pkg::OP_PUSH;
    item.value      = '0;
    item.wait_drain = 1'b1;
    pending_ops.push_back(item);
  endtask

  // Request driver: bursts of transfers separated by random gaps.
  int gap_left;
  int burst_left;

  always @(posedge clk) begin : drive_req
    heap_req_t nxt;
    bit        drained;
    drained = expected_rsp.size() == 0 && !(req_ch.valid && req_ch.ready) &&
              !(rsp_ch.valid && rsp_ch.ready);
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left     <= 0;
      burst_left   <= 1;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_left > 0) begin
        req_ch.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (pending_ops.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (pending_ops[0].wait_drain) begin
        // hold off until every response is back
        req_ch.valid <= 1'b0;
        if (drained) void'(pending_ops.pop_front());
      end else begin
        nxt = pending_ops.pop_front();
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= nxt.opcode;
        req_ch.value  <= nxt.value;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Predict on every request transfer.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      expected_rsp.push_back(apply_heap_op(mhpq_pkg::op_t'(req_ch.opcode), req_ch.value));
  end

  // Response ready follows a randomly chosen pattern, picked anew when its run counter runs out.
  rx_mode_t rx_mode;
  int       rx_left;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_mode      <= RX_OPEN;
      rx_left      <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   rsp_ch.ready <= 1'b1;
        RX_COIN:   rsp_ch.ready <= $urandom_range(0, 1);
        RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        default:   rsp_ch.ready <= (rx_left % 12 == 0);
      endcase
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : check_rsp
    heap_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch($sformatf("response with none pending: value %0d status %0d count %0d",
                                  rsp_ch.popped_value, rsp_ch.status, rsp_ch.count));
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_ch.popped_value !== want.popped_value || rsp_ch.status !== want.status ||
            rsp_ch.count !== want.count)
          report_mismatch($sformatf(
            "expected value %0d status %0d count %0d, got value %0d status %0d count %0d",
            want.popped_value, want.status, want.count,
            rsp_ch.popped_value, rsp_ch.status, rsp_ch.count));
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int phase;
    int run_len;
    int push_pct;

    // Directed: empty pop, extremes, equal priorities.
    queue_op(mhpq_pkg::OP_POP, 32'sd0);
    queue_op(mhpq_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    queue_op(mhpq_pkg::OP_PUSH, 32'sh8000_0000);
    queue_op(mhpq_pkg::OP_PUSH, 32'sd0);
    queue_op(mhpq_pkg::OP_PUSH, -32'sd1);
    queue_op(mhpq_pkg::OP_PUSH, 32'sd5);
    queue_op(mhpq_pkg::OP_PUSH, 32'sd5);
    queue_op(mhpq_pkg::OP_PUSH, 32'sd5);
    repeat (7) queue_op(mhpq_pkg::OP_POP, 32'shFFFF_FFFF);
    queue_op(mhpq_pkg::OP_POP, 32'sh7FFF_FFFF);
    queue_op(mhpq_pkg::OP_PUSH, 32'sd3);
    queue_op(mhpq_pkg::OP_PUSH, 32'sd7);
    queue_op(mhpq_pkg::OP_PUSH, 32'sd7);
    queue_op(mhpq_pkg::OP_PUSH, 32'sd7);
    repeat (4) queue_op(mhpq_pkg::OP_POP, 32'sd0);
    queue_drain_pause();

    // Random: fill to full, drain to empty, and mixed runs.
    while (pending_ops.size() < 1240) begin
      phase = $urandom_range(0, 3);
      case (phase)
        0: begin
          while (plan_size < mhpq_pkg::DEPTH) queue_op(mhpq_pkg::OP_PUSH, pick_priority());
          repeat ($urandom_range(1, 3)) queue_op(mhpq_pkg::OP_PUSH, pick_priority());
        end
        1: begin
          while (plan_size > 0) queue_op(mhpq_pkg::OP_POP, $urandom);
          repeat ($urandom_range(1, 3)) queue_op(mhpq_pkg::OP_POP, $urandom);
        end
        default: begin
          run_len  = $urandom_range(10, 60);
          push_pct = (phase == 2) ? 50 : (($urandom_range(0, 1) == 0) ? 30 : 70);
          repeat (run_len) begin
            if ($urandom_range(0, 99) < push_pct) begin
              queue_op(mhpq_pkg::OP_PUSH, pick_priority());
            end else begin
              queue_op(mhpq_pkg::OP_POP, $urandom);
            end
          end
        end
      endcase
      if ($urandom_range(0, 5) == 0) queue_drain_pause();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending_ops.size() != 0 || req_ch.valid);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_cnt == 0 && expected_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
